// ===== src/sbalu_pkg.sv =====
package sbalu_pkg;

  // operation codes, code 15 is unused
  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_ADDC = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_SUBC = 4'd3,
    CMD_CMP  = 4'd4,
    CMD_DADD = 4'd5,
    CMD_AND  = 4'd6,
    CMD_BIT  = 4'd7,
    CMD_BIC  = 4'd8,
    CMD_BIS  = 4'd9,
    CMD_XOR  = 4'd10,
    CMD_RRA  = 4'd11,
    CMD_RRC  = 4'd12,
    CMD_SWPB = 4'd13,
    CMD_SXT  = 4'd14
  } cmd_t;

  localparam logic [15:0] MASK_WORD = 16'hFFFF;
  localparam logic [15:0] MASK_BYTE = 16'h00FF;
  localparam logic [15:0] SIGN_WORD = 16'h8000;
  localparam logic [15:0] SIGN_BYTE = 16'h0080;
  localparam logic [15:0] SXT_HIGH  = 16'hFF00;
  localparam logic [5:0]  BCD_TEN   = 6'd10;
  localparam logic [5:0]  BCD_TWENTY = 6'd20;
  localparam logic [5:0]  BCD_THIRTY = 6'd30;

  // operand register stage
  typedef struct packed {
    cmd_t        cmd;
    logic        bm;
    logic [15:0] src;
    logic [15:0] dst;
    logic        cin;
    logic        uf;
  } s1_t;

  // partial result stage, decimal add in word mode still has its high byte to do
  typedef struct packed {
    logic        bm;
    logic [15:0] res;
    logic        wb;
    logic        fl;
    logic        uf;
    logic        cy;
    logic        ov;
    logic        dadd_hi;
    logic [1:0]  dadd_c;
    logic [7:0]  src_hi;
    logic [7:0]  dst_hi;
  } s2_t;

  // output stage
  typedef struct packed {
    logic [15:0] res;
    logic        wb;
    logic        fl;
    logic        cy;
    logic        z;
    logic        n;
    logic        ov;
  } s3_t;

  // one decimal digit: returns {carry, digit}, carry may reach 3 for non-bcd digits
  function automatic logic [5:0] bcd_digit(input logic [3:0] a, input logic [3:0] b,
                                           input logic [1:0] c);
    logic [5:0] sum;
    logic [5:0] dig;
    logic [1:0] co;
    sum = {2'b00, a} + {2'b00, b} + {4'b0000, c};
    if (sum >= BCD_THIRTY) begin
      co  = 2'd3;
      dig = sum - BCD_THIRTY;
    end else if (sum >= BCD_TWENTY) begin
      co  = 2'd2;
      dig = sum - BCD_TWENTY;
    end else if (sum >= BCD_TEN) begin
      co  = 2'd1;
      dig = sum - BCD_TEN;
    end else begin
      co  = 2'd0;
      dig = sum;
    end
    return {co, dig[3:0]};
  endfunction

endpackage

// ===== src/sixteen_bit_alu_with_flags_top.sv =====
// channel   | ports                                                        | direction
// ----------+--------------------------------------------------------------+----------
// input     | in_valid, in_stall, in_command, in_byte_mode,                 | in
//           | in_source_operand, in_dest_operand, in_carry_in,             |
//           | in_update_flags                                              |
// result    | out_valid, out_stall, out_result_value, out_write_back,      | out
//           | out_flags_written, out_carry_out, out_zero_flag,             |
//           | out_negative_flag, out_overflow_flag                         |
//
// one item per cycle while the result side does not stall, through three register stages:
// operands, adder/logic plus low decimal byte, high decimal byte plus flags.
// the high-byte decimal digit chain and the 16-bit adder set the stage depth.
// rst_n (synchronous, active low) clears the stage valid bits only.
// a stall on the result side holds each full stage; empty stages still fill.
module sixteen_bit_alu_with_flags_top
  import sbalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_command,
  input  logic        in_byte_mode,
  input  logic [15:0] in_source_operand,
  input  logic [15:0] in_dest_operand,
  input  logic        in_carry_in,
  input  logic        in_update_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result_value,
  output logic        out_write_back,
  output logic        out_flags_written,
  output logic        out_carry_out,
  output logic        out_zero_flag,
  output logic        out_negative_flag,
  output logic        out_overflow_flag
);

  logic v1_r, v2_r, v3_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  logic adv1, adv2, adv3;

  // stage enables, a stage moves when the one after it is empty or moving
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // operand capture with width masking
  always_comb begin
    logic [15:0] w;
    w           = in_byte_mode ? MASK_BYTE : MASK_WORD;
    s1_nxt.cmd  = cmd_t'(in_command);
    s1_nxt.bm   = in_byte_mode;
    s1_nxt.src  = in_source_operand & w;
    s1_nxt.dst  = in_dest_operand & w;
    s1_nxt.cin  = in_carry_in;
    s1_nxt.uf   = in_update_flags;
  end

  // adder, logic ops, rotates and low decimal byte
  always_comb begin
    logic [15:0] w;
    logic [15:0] sb;
    logic [15:0] b;
    logic        ci;
    logic [16:0] sum;
    logic [5:0]  dg0;
    logic [5:0]  dg1;
    w   = s1_r.bm ? MASK_BYTE : MASK_WORD;
    sb  = s1_r.bm ? SIGN_BYTE : SIGN_WORD;
    b   = (s1_r.cmd == CMD_ADD || s1_r.cmd == CMD_ADDC) ? s1_r.src : (~s1_r.src & w);
    ci  = (s1_r.cmd == CMD_ADD) ? 1'b0 :
          ((s1_r.cmd == CMD_SUB || s1_r.cmd == CMD_CMP) ? 1'b1 : s1_r.cin);
    sum = {1'b0, s1_r.dst} + {1'b0, b} + {16'd0, ci};
    dg0 = bcd_digit(s1_r.src[3:0], s1_r.dst[3:0], {1'b0, s1_r.cin});
    dg1 = bcd_digit(s1_r.src[7:4], s1_r.dst[7:4], dg0[5:4]);

    s2_nxt.bm      = s1_r.bm;
    s2_nxt.uf      = s1_r.uf;
    s2_nxt.res     = 16'd0;
    s2_nxt.wb      = 1'b1;
    s2_nxt.fl      = 1'b1;
    s2_nxt.cy      = 1'b0;
    s2_nxt.ov      = 1'b0;
    s2_nxt.dadd_hi = 1'b0;
    s2_nxt.dadd_c  = dg1[5:4];
    s2_nxt.src_hi  = s1_r.src[15:8];
    s2_nxt.dst_hi  = s1_r.dst[15:8];

    unique case (s1_r.cmd) inside
      CMD_ADD, CMD_ADDC, CMD_SUB, CMD_SUBC, CMD_CMP: begin
        s2_nxt.res = sum[15:0] & w;
        s2_nxt.cy  = s1_r.bm ? sum[8] : sum[16];
        s2_nxt.ov  = |((s1_r.dst ^ s2_nxt.res) & (b ^ s2_nxt.res) & sb);
        s2_nxt.wb  = (s1_r.cmd != CMD_CMP);
      end
      CMD_DADD: begin
        s2_nxt.res     = {8'd0, dg1[3:0], dg0[3:0]};
        s2_nxt.cy      = (dg1[5:4] != 2'd0);
        s2_nxt.dadd_hi = !s1_r.bm;
      end
      CMD_AND, CMD_BIT: begin
        s2_nxt.res = s1_r.src & s1_r.dst;
        s2_nxt.cy  = (s2_nxt.res != 16'd0);
        s2_nxt.wb  = (s1_r.cmd != CMD_BIT);
      end
      CMD_BIC: begin
        s2_nxt.res = ~s1_r.src & s1_r.dst;
        s2_nxt.fl  = 1'b0;
      end
      CMD_BIS: begin
        s2_nxt.res = s1_r.src | s1_r.dst;
        s2_nxt.fl  = 1'b0;
      end
      CMD_XOR: begin
        s2_nxt.res = s1_r.src ^ s1_r.dst;
        s2_nxt.cy  = (s2_nxt.res != 16'd0);
        s2_nxt.ov  = |(s1_r.src & s1_r.dst & sb);
      end
      CMD_RRA: begin
        s2_nxt.res = (s1_r.src >> 1) | (s1_r.src & sb);
        s2_nxt.cy  = s1_r.src[0];
      end
      CMD_RRC: begin
        s2_nxt.res = (s1_r.src >> 1) | (s1_r.cin ? sb : 16'd0);
        s2_nxt.cy  = s1_r.src[0];
      end
      CMD_SWPB: begin
        s2_nxt.res = {s1_r.src[7:0], s1_r.src[15:8]} & w;
        s2_nxt.fl  = 1'b0;
      end
      CMD_SXT: begin
        s2_nxt.res = (s1_r.src[7] ? (s1_r.src | SXT_HIGH) : (s1_r.src & MASK_BYTE)) & w;
        s2_nxt.cy  = (s2_nxt.res != 16'd0);
      end
      default: begin
        s2_nxt.wb = 1'b0;
        s2_nxt.fl = 1'b0;
      end
    endcase
  end

  // high decimal byte, flag gating
  always_comb begin
    logic [5:0]  dg2;
    logic [5:0]  dg3;
    logic [15:0] r;
    logic        cy;
    logic        fl;
    dg2 = bcd_digit(s2_r.src_hi[3:0], s2_r.dst_hi[3:0], s2_r.dadd_c);
    dg3 = bcd_digit(s2_r.src_hi[7:4], s2_r.dst_hi[7:4], dg2[5:4]);
    r   = s2_r.res;
    cy  = s2_r.cy;
    if (s2_r.dadd_hi) begin
      r  = {dg3[3:0], dg2[3:0], s2_r.res[7:0]};
      cy = (dg3[5:4] != 2'd0);
    end
    fl         = s2_r.fl & s2_r.uf;
    s3_nxt.res = r;
    s3_nxt.wb  = s2_r.wb;
    s3_nxt.fl  = fl;
    s3_nxt.cy  = fl & cy;
    s3_nxt.z   = fl & (r == 16'd0);
    s3_nxt.n   = fl & (s2_r.bm ? r[7] : r[15]);
    s3_nxt.ov  = fl & s2_r.ov;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) s1_r <= s1_nxt;
    if (adv2 && v1_r) s2_r <= s2_nxt;
    if (adv3 && v2_r) s3_r <= s3_nxt;
  end

  assign out_valid         = v3_r;
  assign out_result_value  = s3_r.res;
  assign out_write_back    = s3_r.wb;
  assign out_flags_written = s3_r.fl;
  assign out_carry_out     = s3_r.cy;
  assign out_zero_flag     = s3_r.z;
  assign out_negative_flag = s3_r.n;
  assign out_overflow_flag = s3_r.ov;

`ifndef NO_ASSERTIONS
  // a full pipeline under a result stall must push back on the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_stall) |-> in_stall)
    else $error("full pipeline accepted an item under stall");

  // zero and negative cannot both be set
  a_zero_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_zero_flag && out_negative_flag))
    else $error("zero and negative flags both set");

  // unwritten flags read as zero
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_flags_written) |->
      !(out_carry_out || out_zero_flag || out_negative_flag || out_overflow_flag))
    else $error("flag set while flags not written");

  // an item in the middle stage reaches the output stage when it is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (!v3_r || !out_stall)) |=> v3_r)
    else $error("item lost between stages");
`endif

endmodule

// ===== tb/sixteen_bit_alu_with_flags_top_tb.sv =====
`timescale 1ns / 100ps

module sixteen_bit_alu_with_flags_top_tb;
  import sbalu_pkg::*;

  localparam logic [3:0] CMD_UNUSED = 4'd15;
  localparam int RANDOM_PER_PHASE = 342;
  localparam int DIR_ROWS = 25;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  // one operation as presented on the input channel
  typedef struct packed {
    logic [3:0]  cmd;
    logic        bm;
    logic [15:0] src;
    logic [15:0] dst;
    logic        cin;
    logic        uf;
  } alu_op_t;

  // one result item, flag bits in the order wb fl cy z n v
  typedef struct packed {
    logic [15:0] value;
    logic        wb;
    logic        fl;
    logic        cy;
    logic        z;
    logic        n;
    logic        v;
  } alu_res_t;

  typedef struct packed {
    alu_op_t  op;
    logic     typed;
    alu_res_t res;
  } dir_row_t;

  localparam alu_res_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_command = 4'd0;
  logic        in_byte_mode = 1'b0;
  logic [15:0] in_source_operand = 16'h0000;
  logic [15:0] in_dest_operand = 16'h0000;
  logic        in_carry_in = 1'b0;
  logic        in_update_flags = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_result_value;
  logic        out_write_back;
  logic        out_flags_written;
  logic        out_carry_out;
  logic        out_zero_flag;
  logic        out_negative_flag;
  logic        out_overflow_flag;

  alu_res_t pending_results[$];
  int src_idle_pct = 19;
  int sink_stall_pct = 61;
  int mismatches = 0;
  int unexpected = 0;
  int items_sent = 0;
  int results_checked = 0;
  int byte_items = 0;
  int decimal_items = 0;
  int quiet_cycles = 0;

  // directed items, expected result typed in where it is obvious
  //                 cmd         bm    src       dst       cin   uf       result   wb fl cy z n v
  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{'{CMD_ADD,    1'b0, 16'h0001, 16'hFFFF, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b111100}},
    '{'{CMD_ADD,    1'b0, 16'h0001, 16'h7FFF, 1'b0, 1'b1}, 1'b1, {16'h8000, 6'b110011}},
    '{'{CMD_ADD,    1'b1, 16'hFF01, 16'h12FF, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b111100}},
    '{'{CMD_ADDC,   1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_SUB,    1'b0, 16'h0001, 16'h8000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_SUBC,   1'b1, 16'h00FF, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_CMP,    1'b0, 16'h1234, 16'h1234, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b011100}},
    '{'{CMD_DADD,   1'b0, 16'h0001, 16'h9999, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_DADD,   1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_DADD,   1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_AND,    1'b0, 16'hFFFF, 16'h0000, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b110100}},
    '{'{CMD_BIT,    1'b0, 16'h8000, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_BIC,    1'b0, 16'h00FF, 16'hFFFF, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_BIS,    1'b1, 16'hA5F0, 16'h5A0F, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_XOR,    1'b0, 16'h8000, 16'h8000, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b110101}},
    '{'{CMD_RRA,    1'b0, 16'h8001, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_RRA,    1'b1, 16'hFF81, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_RRC,    1'b0, 16'h0001, 16'h0000, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_SWPB,   1'b0, 16'h12AB, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_SWPB,   1'b1, 16'h12AB, 16'h0000, 1'b0, 1'b1}, 1'b1, {16'h0000, 6'b100000}},
    '{'{CMD_SXT,    1'b0, 16'h0080, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_SXT,    1'b1, 16'hFF80, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{CMD_UNUSED, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, {16'h0000, 6'b000000}},
    '{'{CMD_ADD,    1'b0, 16'h0001, 16'hFFFF, 1'b0, 1'b0}, 1'b1, {16'h0000, 6'b100000}},
    '{'{CMD_SUBC,   1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1}, 1'b0, NO_RES}
  };

  sixteen_bit_alu_with_flags_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_byte_mode      (in_byte_mode),
    .in_source_operand (in_source_operand),
    .in_dest_operand   (in_dest_operand),
    .in_carry_in       (in_carry_in),
    .in_update_flags   (in_update_flags),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_write_back    (out_write_back),
    .out_flags_written (out_flags_written),
    .out_carry_out     (out_carry_out),
    .out_zero_flag     (out_zero_flag),
    .out_negative_flag (out_negative_flag),
    .out_overflow_flag (out_overflow_flag)
  );

  always #6 clk = ~clk;

  // expected result of one operation
  function automatic alu_res_t alu_predict(input alu_op_t op);
    logic [15:0] wmask;
    logic [15:0] sbit;
    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] b;
    logic [15:0] r;
    logic [16:0] sum;
    logic        cin;
    logic        cy;
    logic        v;
    logic        wb;
    logic        fl;
    int          dsum;
    int          dcarry;
    alu_res_t    res;
    wmask = op.bm ? MASK_BYTE : MASK_WORD;
    sbit  = op.bm ? SIGN_BYTE : SIGN_WORD;
    s  = op.src & wmask;
    d  = op.dst & wmask;
    r  = 16'h0000;
    cy = 1'b0;
    v  = 1'b0;
    wb = 1'b1;
    fl = 1'b1;
    case (op.cmd)
      CMD_ADD, CMD_ADDC, CMD_SUB, CMD_SUBC, CMD_CMP: begin
        b = (op.cmd == CMD_ADD || op.cmd == CMD_ADDC) ? s : (~s & wmask);
        if (op.cmd == CMD_ADD) cin = 1'b0;
        else if (op.cmd == CMD_SUB || op.cmd == CMD_CMP) cin = 1'b1;
        else cin = op.cin;
        sum = {1'b0, d} + {1'b0, b} + {16'h0000, cin};
        r   = sum[15:0] & wmask;
        cy  = op.bm ? sum[8] : sum[16];
        v   = |((d ^ r) & (b ^ r) & sbit);
        wb  = (op.cmd != CMD_CMP);
      end
      CMD_DADD: begin
        // digit chain, non-decimal digits can pass on up to three
        dcarry = int'(op.cin);
        for (int i = 0; i < (op.bm ? 2 : 4); i++) begin
          dsum = int'(s[i*4 +: 4]) + int'(d[i*4 +: 4]) + dcarry;
          if (dsum > 9) begin
            dcarry = dsum / 10;
            dsum   = dsum % 10;
          end else begin
            dcarry = 0;
          end
          r[i*4 +: 4] = dsum[3:0];
        end
        r  = r & wmask;
        cy = (dcarry != 0);
      end
      CMD_AND, CMD_BIT: begin
        r  = s & d;
        cy = |r;
        wb = (op.cmd != CMD_BIT);
      end
      CMD_BIC: begin
        r  = ~s & d & wmask;
        fl = 1'b0;
      end
      CMD_BIS: begin
        r  = s | d;
        fl = 1'b0;
      end
      CMD_XOR: begin
        r  = s ^ d;
        cy = |r;
        v  = |(s & d & sbit);
      end
      CMD_RRA: begin
        r  = (s >> 1) | (s & sbit);
        cy = s[0];
      end
      CMD_RRC: begin
        r  = (s >> 1) | (op.cin ? sbit : 16'h0000);
        cy = s[0];
      end
      CMD_SWPB: begin
        r  = {s[7:0], s[15:8]} & wmask;
        fl = 1'b0;
      end
      CMD_SXT: begin
        r  = (s[7] ? (s | SXT_HIGH) : (s & MASK_BYTE)) & wmask;
        cy = |r;
      end
      default: begin
        r  = 16'h0000;
        wb = 1'b0;
        fl = 1'b0;
      end
    endcase
    // flags read as zero whenever they are not written
    fl        = fl & op.uf;
    res.value = r;
    res.wb    = wb;
    res.fl    = fl;
    res.cy    = fl & cy;
    res.z     = fl & (r == 16'h0000);
    res.n     = fl & (|(r & sbit));
    res.v     = fl & v;
    return res;
  endfunction

  // operand mix: corner values, decimal-looking words and plain random
  function automatic logic [15:0] pick_operand(input logic decimal);
    logic [15:0] val;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 1 || (decimal && sel < 7)) begin
      for (int i = 0; i < 4; i++) val[i*4 +: 4] = 4'($urandom_range(0, 9));
    end else if (sel == 0) begin
      case ($urandom_range(0, 8))
        0: val = 16'h0000;
        1: val = 16'hFFFF;
        2: val = 16'h8000;
        3: val = 16'h7FFF;
        4: val = 16'h00FF;
        5: val = 16'h0080;
        6: val = 16'h007F;
        7: val = 16'hFF00;
        default: val = 16'h0001;
      endcase
    end else begin
      val = 16'($urandom_range(0, 65535));
    end
    return val;
  endfunction

  // present one item, hold it until accepted, then log its expected result
  task automatic send_item(input alu_op_t op, input logic typed, input alu_res_t res);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= op.cmd;
    in_byte_mode      <= op.bm;
    in_source_operand <= op.src;
    in_dest_operand   <= op.dst;
    in_carry_in       <= op.cin;
    in_update_flags   <= op.uf;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? res : alu_predict(op));
    items_sent++;
    if (op.bm) byte_items++;
    if (op.cmd == CMD_DADD) decimal_items++;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_result_value, out_write_back, out_flags_written, out_carry_out,
             out_zero_flag, out_negative_flag, out_overflow_flag};
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MAX_REPORTS)
          $display("unexpected result item: value %h", got.value);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches + unexpected <= MAX_REPORTS) begin
            $display("result %0d: value %h/%h wb %b/%b fl %b/%b (exp/act)",
                     results_checked, want.value, got.value, want.wb, got.wb,
                     want.fl, got.fl);
            $display("  c %b/%b z %b/%b n %b/%b v %b/%b (exp/act)",
                     want.cy, got.cy, want.z, got.z, want.n, got.n, want.v, got.v);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sixteen_bit_alu_with_flags_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    alu_op_t op;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_table[i].op, dir_table[i].typed, dir_table[i].res);

    // random items over three flow-control phases
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct   = 61;
        sink_stall_pct = 19;
      end else if (phase == 2) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        op.cmd = 4'($urandom_range(0, 14));
        op.bm  = 1'($urandom_range(0, 1));
        op.cin = 1'($urandom_range(0, 1));
        op.uf  = ($urandom_range(0, 7) != 0);
        op.src = pick_operand(op.cmd == CMD_DADD);
        op.dst = pick_operand(op.cmd == CMD_DADD);
        send_item(op, 1'b0, NO_RES);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d directed, %0d byte mode, %0d decimal add)",
             items_sent, DIR_ROWS, byte_items, decimal_items);
    $display("%0d results checked, %0d wrong, %0d unexpected, %0d missing",
             results_checked, mismatches, unexpected, pending_results.size());
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("sixteen_bit_alu_with_flags_top: match");
    end else begin
      $display("sixteen_bit_alu_with_flags_top: mismatch");
    end
    $finish;
  end

endmodule
